/* src/gmas_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and register map of the gated moving average block
// used by the top level, gmas_ctrl and gmas_dp; depends on nothing

package gmas_pkg;

  // default window depth and field widths
  localparam int WINDOW_DEF = 16;
  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 14;
  localparam int THR_W      = 13;
  localparam int LIMIT_W    = 16;

  // one quotient bit per divider step
  localparam int DIV_STEPS  = SAMPLE_W;

  // settle counter fold-back
  localparam logic [COUNT_W-1:0] FOLD_ABOVE = COUNT_W'(10000);
  localparam logic [COUNT_W-1:0] FOLD_TO    = COUNT_W'(5000);

  // register reset values
  localparam logic [LIMIT_W-1:0] CHANGE_LIMIT_RST = LIMIT_W'(500);
  localparam logic [THR_W-1:0]   SETTLE_CAL_RST   = THR_W'(100);
  localparam logic [THR_W-1:0]   SETTLE_NORM_RST  = THR_W'(20);

  // register map
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_CAL_MODE     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHANGE_LIMIT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE_CAL   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE_NORM  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIVIDE,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the input item
    logic update;    // write ring, update sum, load divider
    logic div_step;  // one restoring division step
    logic finish;    // settle logic, load the result item
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new item
  } sts_t;

  // configuration register set
  typedef struct packed {
    logic               cal_mode;
    logic [LIMIT_W-1:0] change_limit;
    logic [THR_W-1:0]   settle_cal;
    logic [THR_W-1:0]   settle_norm;
  } cfg_t;

endpackage

`default_nettype wire

/* src/gated_moving_average_stability.sv */
`timescale 1ns / 1ps
`default_nettype none
// top level of the gated moving average with settle detection
// holds the configuration registers; depends on gmas_pkg, gmas_ctrl, gmas_dp, gmas_ram
// usage
//   input channel (in_valid / in_ready): a 16-bit sample and an average_ok flag;
//   a flag of 0 restarts the window and the raw sample passes through, a flag
//   of 1 adds the sample to a ring of WINDOW entries
//   result channel (out_valid / out_ready): filtered value, stable flag and
//   settle count, one result item for every input item, in order
//   configuration port: apb-style, registers at byte addresses 0, 4, 8, 12
//   (cal_mode, change_limit, settle_count_cal, settle_count_normal); write
//   only while no item is in flight
// timing
//   an averaged item passes through acceptance, a ring read, a sum update,
//   16 divider steps (one quotient bit a cycle) and the settle cycle; a
//   pass-through item goes from acceptance straight to the settle cycle;
//   the result is valid the cycle after the settle cycle
// reset
//   rst_n low clears ring position, fill state, sum, settle count and stable
//   flag and loads the register reset values; ring contents are never read
//   before being written
// stalls
//   a waiting result sits in the output register; the next item is still
//   taken and worked on, and is held at the settle cycle until out_ready

module gated_moving_average_stability #(
  parameter int WINDOW = gmas_pkg::WINDOW_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [gmas_pkg::SAMPLE_W-1:0]       in_sample,
  input  wire logic                                in_average_ok,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [gmas_pkg::SAMPLE_W-1:0]       out_filtered,
  output logic                                     out_stable,
  output logic      [gmas_pkg::COUNT_W-1:0]        out_settle_count,
  // configuration port
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [gmas_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [gmas_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic      [gmas_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready
);

  // configuration registers
  logic                             cal_mode_r;
  logic [gmas_pkg::LIMIT_W-1:0]     change_limit_r;
  logic [gmas_pkg::THR_W-1:0]       settle_cal_r;
  logic [gmas_pkg::THR_W-1:0]       settle_norm_r;

  logic                             cfg_wr;
  logic [gmas_pkg::REG_IDX_W-1:0]   reg_idx;

  // register index from the word address, byte lanes ignored
  assign reg_idx    = cfg_paddr[gmas_pkg::CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_mode_r     <= 1'b0;
      change_limit_r <= gmas_pkg::CHANGE_LIMIT_RST;
      settle_cal_r   <= gmas_pkg::SETTLE_CAL_RST;
      settle_norm_r  <= gmas_pkg::SETTLE_NORM_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        gmas_pkg::REG_CAL_MODE:     cal_mode_r     <= cfg_pwdata[0];
        gmas_pkg::REG_CHANGE_LIMIT: change_limit_r <= cfg_pwdata[gmas_pkg::LIMIT_W-1:0];
        gmas_pkg::REG_SETTLE_CAL:   settle_cal_r   <= cfg_pwdata[gmas_pkg::THR_W-1:0];
        gmas_pkg::REG_SETTLE_NORM:  settle_norm_r  <= cfg_pwdata[gmas_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read-back, zero-extended
  always_comb begin
    unique case (reg_idx)
      gmas_pkg::REG_CAL_MODE:
        cfg_prdata = gmas_pkg::CFG_DATA_W'(cal_mode_r);
      gmas_pkg::REG_CHANGE_LIMIT:
        cfg_prdata = gmas_pkg::CFG_DATA_W'(change_limit_r);
      gmas_pkg::REG_SETTLE_CAL:
        cfg_prdata = gmas_pkg::CFG_DATA_W'(settle_cal_r);
      gmas_pkg::REG_SETTLE_NORM:
        cfg_prdata = gmas_pkg::CFG_DATA_W'(settle_norm_r);
      default:
        cfg_prdata = '0;
    endcase
  end

  gmas_pkg::cfg_t cfg;
  assign cfg.cal_mode     = cal_mode_r;
  assign cfg.change_limit = change_limit_r;
  assign cfg.settle_cal   = settle_cal_r;
  assign cfg.settle_norm  = settle_norm_r;

  // controller and datapath
  gmas_pkg::cmd_t cmd;
  gmas_pkg::sts_t sts;

  gmas_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_average_ok (in_average_ok),
    .in_ready      (in_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  gmas_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg              (cfg),
    .in_sample        (in_sample),
    .in_average_ok    (in_average_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_filtered     (out_filtered),
    .out_stable       (out_stable),
    .out_settle_count (out_settle_count)
  );

endmodule

`default_nettype wire

/* src/gmas_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// generic single-port ram with registered read
// no dependencies

module gmas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/gmas_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// controller state machine: input handshake and sequencing of the datapath
// depends on gmas_pkg

module gmas_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_average_ok,
  output logic               in_ready,
  input  wire gmas_pkg::sts_t sts,
  output gmas_pkg::cmd_t     cmd
);

  localparam int CNT_W = $clog2(gmas_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(gmas_pkg::DIV_STEPS - 1);

  gmas_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gmas_pkg::S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      gmas_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_average_ok ? gmas_pkg::S_READ : gmas_pkg::S_FINISH;
        end
      end
      gmas_pkg::S_READ: begin
        state_nxt = gmas_pkg::S_UPDATE;
      end
      gmas_pkg::S_UPDATE: begin
        state_nxt = gmas_pkg::S_DIVIDE;
        step_nxt  = '0;
      end
      gmas_pkg::S_DIVIDE: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = gmas_pkg::S_FINISH;
        end
      end
      gmas_pkg::S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = gmas_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gmas_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      gmas_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      gmas_pkg::S_READ: begin
        // ring output settles on the entry about to be replaced
        cmd = '0;
      end
      gmas_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
      end
      gmas_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      gmas_pkg::S_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (sts.out_free && state_r == gmas_pkg::S_FINISH))
    else $error("result loaded into an occupied output register");

  a_divide_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gmas_pkg::S_UPDATE) |=> (state_r == gmas_pkg::S_DIVIDE && step_r == '0))
    else $error("divider not started from its first step");

endmodule

`default_nettype wire

/* src/gmas_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// datapath: window ring, running sum, bit-serial divider, settle logic, result register
// depends on gmas_pkg and gmas_ram

module gmas_dp #(
  parameter int WINDOW = gmas_pkg::WINDOW_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire gmas_pkg::cmd_t                   cmd,
  output gmas_pkg::sts_t                        sts,
  input  wire gmas_pkg::cfg_t                   cfg,
  input  wire logic [gmas_pkg::SAMPLE_W-1:0]    in_sample,
  input  wire logic                             in_average_ok,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [gmas_pkg::SAMPLE_W-1:0]    out_filtered,
  output logic                                  out_stable,
  output logic      [gmas_pkg::COUNT_W-1:0]     out_settle_count
);

  localparam int SW_ = gmas_pkg::SAMPLE_W;
  localparam int AW  = $clog2(WINDOW);
  localparam int DW  = $clog2(WINDOW + 1);
  localparam int SUM_W = SW_ + AW;
  localparam int CW  = gmas_pkg::COUNT_W;

  // captured item
  logic [SW_-1:0]   smp_q_r;
  logic             avg_q_r;

  // ring bookkeeping
  logic [AW-1:0]    write_pos_r;
  logic             full_r;
  logic [SUM_W-1:0] sum_r;
  logic [SW_-1:0]   ram_rdata;

  // divider
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [SW_-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]    div_r;

  // settle state, also the result fields
  logic [SW_-1:0]   prev_r;
  logic [CW-1:0]    steady_r;
  logic             stable_r;
  logic             out_valid_r;

  gmas_ram #(
    .WIDTH (SW_),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .addr  (write_pos_r),
    .wdata (smp_q_r),
    .rdata (ram_rdata)
  );

  // ring update
  logic [SUM_W-1:0] sum_nxt;
  logic [AW:0]      pos_inc;
  logic             wrap;
  logic             full_nxt;
  logic [DW-1:0]    divisor;

  always_comb begin
    sum_nxt  = sum_r - (full_r ? {{AW{1'b0}}, ram_rdata} : '0) + {{AW{1'b0}}, smp_q_r};
    pos_inc  = {1'b0, write_pos_r} + 1'b1;
    wrap     = (pos_inc == (AW + 1)'(WINDOW));
    full_nxt = full_r | wrap;
    divisor  = full_nxt ? DW'(WINDOW) : DW'(pos_inc);
  end

  // restoring division step, the remainder stays below the divisor
  logic [DW:0] trial;
  logic [DW:0] trial_sub;
  logic        take;

  always_comb begin
    trial     = {rem_r, quo_r[SW_-1]};
    trial_sub = trial - {1'b0, div_r};
    take      = (trial >= {1'b0, div_r});
    rem_nxt   = take ? trial_sub[DW-1:0] : trial[DW-1:0];
    quo_nxt   = {quo_r[SW_-2:0], take};
  end

  // settle logic
  logic [SW_-1:0] filt;
  logic [SW_-1:0] diff;
  logic           jump;
  logic [CW-1:0]  cnt_inc;
  logic [CW-1:0]  cnt_fold;
  logic [gmas_pkg::THR_W-1:0] thr;
  logic [CW-1:0]  steady_nxt;
  logic           stable_nxt;

  always_comb begin
    filt     = avg_q_r ? quo_r : smp_q_r;
    diff     = (filt >= prev_r) ? (filt - prev_r) : (prev_r - filt);
    jump     = (diff > cfg.change_limit);
    cnt_inc  = steady_r + 1'b1;
    cnt_fold = (cnt_inc > gmas_pkg::FOLD_ABOVE) ? gmas_pkg::FOLD_TO : cnt_inc;
    thr      = cfg.cal_mode ? cfg.settle_cal : cfg.settle_norm;
    if (jump) begin
      steady_nxt = '0;
      stable_nxt = 1'b0;
    end else begin
      steady_nxt = cnt_fold;
      stable_nxt = stable_r | (cnt_fold > CW'(thr));
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_q_r <= in_sample;
      avg_q_r <= in_average_ok;
    end
    if (cmd.update) begin
      rem_r <= DW'(sum_nxt[SUM_W-1:SW_]);
      quo_r <= sum_nxt[SW_-1:0];
      div_r <= divisor;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r <= '0;
      full_r      <= 1'b0;
      sum_r       <= '0;
      prev_r      <= '0;
      steady_r    <= '0;
      stable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture && !in_average_ok) begin
        write_pos_r <= '0;
        full_r      <= 1'b0;
        sum_r       <= '0;
      end else if (cmd.update) begin
        write_pos_r <= wrap ? '0 : pos_inc[AW-1:0];
        full_r      <= full_nxt;
        sum_r       <= sum_nxt;
      end
      if (cmd.finish) begin
        prev_r      <= filt;
        steady_r    <= steady_nxt;
        stable_r    <= stable_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_filtered     = prev_r;
  assign out_stable       = stable_r;
  assign out_settle_count = steady_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    write_pos_r < AW'(WINDOW - 1) || write_pos_r == AW'(WINDOW - 1))
    else $error("ring position beyond the window");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    steady_r <= gmas_pkg::FOLD_ABOVE)
    else $error("settle count above the fold limit");

  a_stable_count: assert property (@(posedge clk) disable iff (!rst_n)
    stable_r |-> steady_r != '0)
    else $error("stable flag with an empty settle count");

endmodule

`default_nettype wire
